// ----- rtl/core/jsu_pkg.sv -----
// Shared types, constants and helpers for the JSON string unescape unit.
package jsu_pkg;

  typedef enum logic [3:0] {
    PH_IDLE   = 4'd0,
    PH_BODY   = 4'd1,
    PH_ESC    = 4'd2,
    PH_HEX1   = 4'd3,
    PH_SUR_BS = 4'd4,
    PH_SUR_U  = 4'd5,
    PH_HEX2   = 4'd6,
    PH_DRAIN  = 4'd7
  } phase_e;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_NO_OPEN   = 3'd1,
    ST_NO_CLOSE  = 3'd2,
    ST_SHORT_ESC = 3'd3,
    ST_NO_SECOND = 3'd4,
    ST_BAD_LOW   = 3'd5,
    ST_BAD_HEX   = 3'd6
  } status_e;

  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_U      = 8'h75;

  localparam int unsigned MaxRes = 4;

  // One result word.
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       last;
    status_e    status;
  } res_t;

  // Parser state carried from word to word.
  typedef struct packed {
    phase_e      phase;
    logic [1:0]  hex_cnt;
    logic [15:0] acc;
    logic [9:0]  hs;
  } pstate_t;

  // Decoder result: next state plus up to four result words.
  typedef struct packed {
    pstate_t          nxt;
    logic [2:0]       nres;
    res_t [MaxRes-1:0] res;
  } dec_t;

  // Hex digit value; bit 4 set for a non-hex byte.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [4:0] v;
    v = 5'h10;
    if (c >= 8'h30 && c <= 8'h39) v = {1'b0, c[3:0]};
    else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66))
      v = {1'b0, c[3:0] + 4'd9};
    return v;
  endfunction

endpackage

// ----- rtl/core/jsu_in_if.sv -----
// Input channel: one string byte or end-of-stream marker per word.
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic [7:0] in_byte;

  modport source (output valid, output kind, output in_byte, input ready);
  modport sink   (input valid, input kind, input in_byte, output ready);
endinterface

// ----- rtl/core/jsu_out_if.sv -----
// Output channel: one decoded byte, end marker or error report per word.
interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;
  logic [2:0] status;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  output status, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last,
                  input status, output ready);
endinterface

// ----- rtl/core/jsu_decode.sv -----
// Combinational per-word parser: state and input byte to next state and results.
module jsu_decode (
  input  jsu_pkg::pstate_t cur_i,
  input  logic             kind_i,
  input  logic [7:0]       byte_i,
  output jsu_pkg::dec_t    dec_o
);
  import jsu_pkg::*;

  function automatic res_t mk_byte(input logic [7:0] b);
    res_t r;
    r.out_byte   = b;
    r.byte_valid = 1'b1;
    r.last       = 1'b0;
    r.status     = ST_OK;
    return r;
  endfunction

  function automatic res_t mk_end(input status_e st);
    res_t r;
    r.out_byte   = 8'h00;
    r.byte_valid = 1'b0;
    r.last       = 1'b1;
    r.status     = st;
    return r;
  endfunction

  function automatic logic [7:0] simple_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h62:   r = 8'h08;
      8'h66:   r = 8'h0C;
      8'h6E:   r = 8'h0A;
      8'h72:   r = 8'h0D;
      8'h74:   r = 8'h09;
      default: r = c;
    endcase
    return r;
  endfunction

  logic [4:0]  hv;
  logic [15:0] acc_n;
  logic [20:0] cp;

  assign hv    = hex_value(byte_i);
  assign acc_n = {cur_i.acc[11:0], hv[3:0]};
  assign cp    = 21'h10000 + {1'b0, cur_i.hs, acc_n[9:0]};

  always_comb begin
    dec_o.nxt  = cur_i;
    dec_o.nres = 3'd0;
    dec_o.res  = '0;
    if (kind_i) begin
      case (cur_i.phase)
        PH_IDLE: begin
          dec_o.res[0] = mk_end(ST_NO_OPEN);
          dec_o.nres   = 3'd1;
        end
        PH_BODY: begin
          dec_o.res[0] = mk_end(ST_NO_CLOSE);
          dec_o.nres   = 3'd1;
        end
        PH_ESC, PH_HEX1, PH_HEX2: begin
          dec_o.res[0] = mk_end(ST_SHORT_ESC);
          dec_o.nres   = 3'd1;
        end
        PH_SUR_BS, PH_SUR_U: begin
          dec_o.res[0] = mk_end(ST_NO_SECOND);
          dec_o.nres   = 3'd1;
        end
        default: ;
      endcase
      dec_o.nxt = '{phase: PH_IDLE, hex_cnt: 2'd0, acc: 16'h0000, hs: 10'h000};
    end else begin
      case (cur_i.phase)
        PH_IDLE: begin
          if (byte_i == CH_QUOTE) begin
            dec_o.nxt.phase = PH_BODY;
          end else begin
            dec_o.res[0]    = mk_end(ST_NO_OPEN);
            dec_o.nres      = 3'd1;
            dec_o.nxt.phase = PH_DRAIN;
          end
        end
        PH_BODY: begin
          if (byte_i == CH_QUOTE) begin
            dec_o.res[0]    = mk_end(ST_OK);
            dec_o.nres      = 3'd1;
            dec_o.nxt.phase = PH_DRAIN;
          end else if (byte_i == CH_BSLASH) begin
            dec_o.nxt.phase = PH_ESC;
          end else begin
            dec_o.res[0] = mk_byte(byte_i);
            dec_o.nres   = 3'd1;
          end
        end
        PH_ESC: begin
          if (byte_i == CH_U) begin
            dec_o.nxt.phase   = PH_HEX1;
            dec_o.nxt.hex_cnt = 2'd0;
            dec_o.nxt.acc     = 16'h0000;
          end else begin
            dec_o.res[0]    = mk_byte(simple_escape(byte_i));
            dec_o.nres      = 3'd1;
            dec_o.nxt.phase = PH_BODY;
          end
        end
        PH_HEX1, PH_HEX2: begin
          if (hv[4]) begin
            dec_o.res[0]    = mk_end(ST_BAD_HEX);
            dec_o.nres      = 3'd1;
            dec_o.nxt.phase = PH_DRAIN;
          end else begin
            dec_o.nxt.acc = acc_n;
            if (cur_i.hex_cnt == 2'd3) begin
              dec_o.nxt.hex_cnt = 2'd0;
              if (cur_i.phase == PH_HEX1) begin
                dec_o.nxt.phase = PH_BODY;
                if (acc_n <= 16'h007F) begin
                  dec_o.res[0] = mk_byte(acc_n[7:0]);
                  dec_o.nres   = 3'd1;
                end else if (acc_n <= 16'h07FF) begin
                  dec_o.res[0] = mk_byte({3'b110, acc_n[10:6]});
                  dec_o.res[1] = mk_byte({2'b10, acc_n[5:0]});
                  dec_o.nres   = 3'd2;
                end else if (acc_n inside {[16'hD800:16'hDBFF]}) begin
                  dec_o.nxt.hs    = acc_n[9:0];
                  dec_o.nxt.phase = PH_SUR_BS;
                end else begin
                  dec_o.res[0] = mk_byte({4'hE, acc_n[15:12]});
                  dec_o.res[1] = mk_byte({2'b10, acc_n[11:6]});
                  dec_o.res[2] = mk_byte({2'b10, acc_n[5:0]});
                  dec_o.nres   = 3'd3;
                end
              end else begin
                if (acc_n inside {[16'hDC00:16'hDFFF]}) begin
                  dec_o.res[0]    = mk_byte({5'b11110, cp[20:18]});
                  dec_o.res[1]    = mk_byte({2'b10, cp[17:12]});
                  dec_o.res[2]    = mk_byte({2'b10, cp[11:6]});
                  dec_o.res[3]    = mk_byte({2'b10, cp[5:0]});
                  dec_o.nres      = 3'd4;
                  dec_o.nxt.phase = PH_BODY;
                end else begin
                  dec_o.res[0]    = mk_end(ST_BAD_LOW);
                  dec_o.nres      = 3'd1;
                  dec_o.nxt.phase = PH_DRAIN;
                end
              end
            end else begin
              dec_o.nxt.hex_cnt = cur_i.hex_cnt + 2'd1;
            end
          end
        end
        PH_SUR_BS: begin
          if (byte_i == CH_BSLASH) begin
            dec_o.nxt.phase = PH_SUR_U;
          end else begin
            dec_o.res[0]    = mk_end(ST_NO_SECOND);
            dec_o.nres      = 3'd1;
            dec_o.nxt.phase = PH_DRAIN;
          end
        end
        PH_SUR_U: begin
          if (byte_i == CH_U) begin
            dec_o.nxt.phase   = PH_HEX2;
            dec_o.nxt.hex_cnt = 2'd0;
            dec_o.nxt.acc     = 16'h0000;
          end else begin
            dec_o.res[0]    = mk_end(ST_NO_SECOND);
            dec_o.nres      = 3'd1;
            dec_o.nxt.phase = PH_DRAIN;
          end
        end
        default: begin
          dec_o.nxt.phase = PH_DRAIN;
        end
      endcase
    end
  end

endmodule

// ----- rtl/core/json_string_unescape_utf8_unit.sv -----
// Path: a word is held in the input register, then decoded into the result buffer, which feeds the output.
// Throughput: one input word per cycle while each yields at most one result and the output is ready;
//   a \u escape that encodes to N bytes holds the input side until they leave by the single output port.
// The input register takes a new word while results of the previous one still drain.
// Reset (rst_ni low, asynchronous): parser idle awaiting the opening quote, buffers empty.
// Output words for one input word leave in order from a four-entry result buffer.
module json_string_unescape_utf8_unit (
  input logic clk_i,
  input logic rst_ni,
  jsu_in_if.sink    in_i,
  jsu_out_if.source out_o
);
  import jsu_pkg::*;

  // Input register (skid between input handshake and decoder).
  logic       in_full_q;
  logic       kind_q;
  logic [7:0] byte_q;

  // Parser state.
  pstate_t st_q;
  dec_t    dec;

  // Result buffer: results of one decoded word, read out by pointer.
  res_t [MaxRes-1:0] res_q;
  logic [2:0]        cnt_q;
  logic [1:0]        rd_q;

  logic pop;
  logic load;

  jsu_decode u_decode (
    .cur_i  (st_q),
    .kind_i (kind_q),
    .byte_i (byte_q),
    .dec_o  (dec)
  );

  assign pop  = out_o.valid && out_o.ready;
  // The buffer is free for the next decode once its last word leaves.
  assign load = in_full_q && ((cnt_q == 3'd0) || ((cnt_q == 3'd1) && out_o.ready));

  assign in_i.ready = !in_full_q || load;

  assign out_o.valid      = (cnt_q != 3'd0);
  assign out_o.out_byte   = res_q[rd_q].out_byte;
  assign out_o.byte_valid = res_q[rd_q].byte_valid;
  assign out_o.last       = res_q[rd_q].last;
  assign out_o.status     = res_q[rd_q].status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_full_q <= 1'b0;
    end else if (in_i.valid && in_i.ready) begin
      in_full_q <= 1'b1;
    end else if (load) begin
      in_full_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.valid && in_i.ready) begin
      kind_q <= in_i.kind;
      byte_q <= in_i.in_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q  <= '{phase: PH_IDLE, hex_cnt: 2'd0, acc: 16'h0000, hs: 10'h000};
      cnt_q <= 3'd0;
      rd_q  <= 2'd0;
    end else if (load) begin
      st_q  <= dec.nxt;
      cnt_q <= dec.nres;
      rd_q  <= 2'd0;
    end else if (pop) begin
      cnt_q <= cnt_q - 3'd1;
      rd_q  <= rd_q + 2'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= dec.res;
    end
  end

  // Buffer never overfills.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'd4)
    else $error("result count out of range");

  // End and error words are always alone, so they are the final word in the buffer.
  a_last_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.last) |-> (cnt_q == 3'd1))
    else $error("last word not final in buffer");

  // A decode loads exactly the number of results the decoder produced.
  a_load_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |=> (cnt_q == $past(dec.nres)))
    else $error("result count mismatch after load");

  // A decode never overwrites words still waiting.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load |-> ((cnt_q == 3'd0) || pop))
    else $error("result buffer overwritten");

endmodule
